@@ sv/stp_pkg.sv @@
// Package for the stepper half-step sequencer.
// Holds payload and configuration types, register indexes and the coil table.
// No dependencies.
`default_nettype none

package stp_pkg;

    localparam int PhaseW  = 3;
    localparam int DelayW  = 8;
    localparam int CoilW   = 4;
    localparam int ButtonW = 4;
    localparam int CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] CFG_SLOWEST = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_FASTEST = 1'd1;

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_BUTTON = 1'b1;

    localparam int BTN_RIGHT  = 0;
    localparam int BTN_SLOWER = 1;
    localparam int BTN_LEFT   = 2;
    localparam int BTN_FASTER = 3;

    localparam logic [DelayW-1:0] SLOWEST_RESET = 8'd20;
    localparam logic [DelayW-1:0] FASTEST_RESET = 8'd1;
    localparam logic [DelayW-1:0] DELAY_RESET   = 8'd15;
    localparam logic [DelayW-1:0] DELAY_MAX     = 8'd255;
    localparam logic [DelayW-1:0] DELAY_MIN     = 8'd1;

    typedef struct packed {
        logic               req_type;
        logic [ButtonW-1:0] buttons;
    } t_in_item;

    typedef struct packed {
        logic [CoilW-1:0]  coil_pattern;
        logic [DelayW-1:0] delay_ms_now;
        logic              turning_left;
    } t_out_item;

    typedef struct packed {
        logic [DelayW-1:0] slowest_delay_ms;
        logic [DelayW-1:0] fastest_delay_ms;
    } t_cfg;

    function automatic logic [CoilW-1:0] coil_of(input logic [PhaseW-1:0] phase);
        logic [CoilW-1:0] pattern;
        case (phase)
            3'd0:    pattern = 4'b1100;
            3'd1:    pattern = 4'b0100;
            3'd2:    pattern = 4'b0110;
            3'd3:    pattern = 4'b0010;
            3'd4:    pattern = 4'b0011;
            3'd5:    pattern = 4'b0001;
            3'd6:    pattern = 4'b1001;
            3'd7:    pattern = 4'b1000;
            default: pattern = 4'b1100;
        endcase
        return pattern;
    endfunction

endpackage

`default_nettype wire

@@ sv/stp_cfg.sv @@
// Configuration registers of the stepper half-step sequencer.
// Depends on stp_pkg.
`default_nettype none

module stp_cfg import stp_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [CfgIdxW-1:0]        i_cfg_idx,
    input  wire logic [DelayW-1:0]         i_cfg_data,
    output t_cfg                           o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLOWEST: n_cfg.slowest_delay_ms = i_cfg_data;
                CFG_FASTEST: n_cfg.fastest_delay_ms = i_cfg_data;
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slowest_delay_ms <= SLOWEST_RESET;
            r_cfg.fastest_delay_ms <= FASTEST_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ sv/stp_core.sv @@
// Sequencer state and its update for one transaction.
// Depends on stp_pkg.
`default_nettype none

module stp_core import stp_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_in_item  i_item,
    input  wire t_cfg      i_cfg,
    output t_out_item      o_result
);

    logic [PhaseW-1:0] r_phase, n_phase;
    logic              r_dir,   n_dir;
    logic [DelayW-1:0] r_delay, n_delay;
    logic [DelayW-1:0] r_ticks, n_ticks;
    logic [DelayW-1:0] ticks_inc;
    logic [DelayW-1:0] delay_slow;

    always_comb begin
        n_phase    = r_phase;
        n_dir      = r_dir;
        n_delay    = r_delay;
        n_ticks    = r_ticks;
        ticks_inc  = (r_ticks != DELAY_MAX) ? r_ticks + 8'd1 : r_ticks;
        delay_slow = r_delay;
        if (i_item.req_type == REQ_TICK) begin
            n_ticks = ticks_inc;
            if (ticks_inc >= r_delay) begin
                n_ticks = '0;
                n_phase = r_dir ? r_phase - 3'd1 : r_phase + 3'd1;
            end
        end else begin
            if (i_item.buttons[BTN_SLOWER] && r_delay < i_cfg.slowest_delay_ms
                    && r_delay != DELAY_MAX) begin
                delay_slow = r_delay + 8'd1;
            end
            n_delay = delay_slow;
            if (i_item.buttons[BTN_FASTER] && delay_slow > i_cfg.fastest_delay_ms
                    && delay_slow > DELAY_MIN) begin
                n_delay = delay_slow - 8'd1;
            end
            if (i_item.buttons[BTN_LEFT]) begin
                n_dir = 1'b1;
            end else if (i_item.buttons[BTN_RIGHT]) begin
                n_dir = 1'b0;
            end
        end
        o_result.coil_pattern = coil_of(n_phase);
        o_result.delay_ms_now = n_delay;
        o_result.turning_left = n_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_dir   <= 1'b0;
            r_delay <= DELAY_RESET;
            r_ticks <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_dir   <= n_dir;
            r_delay <= n_delay;
            r_ticks <= n_ticks;
        end
    end

endmodule

`default_nettype wire

@@ sv/stepper_half_step_sequencer.sv @@
// Top level of the stepper half-step sequencer: input register, core, result register.
// Depends on stp_pkg, stp_cfg and stp_core.
//
//   channel | direction | handshake               | payload
//   in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//   out     | output    | o_out_valid/ i_out_stall| o_out_item (t_out_item)
//   cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One transaction per cycle while the output does not stall; an accepted item passes
// from the input register through the core, which updates its state, to the result register.
// Reset is synchronous, active low; it clears state and both valid flags.
// A stall on the output holds the result register and, while it holds an item, the input register.
`default_nettype none

module stepper_half_step_sequencer import stp_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_item,
    input  wire logic                 i_cfg_we,
    input  wire logic [CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [DelayW-1:0]    i_cfg_data
);

    t_cfg      cfg;
    t_out_item result;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      out_open;
    logic      fire;

    assign out_open   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_open;
    assign o_in_stall = r_in_valid && !out_open;

    stp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    stp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_open) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for stepper_half_step_sequencer.
// Drives ticks and button events with random gaps and output stalls, predicts every
// result in the bench, and needs stp_pkg and the RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stp_pkg::*;

    typedef enum int {MIX_ALL, PUSH_SLOWER, PUSH_FASTER} t_press_bias;

    localparam int RUN_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;

    // coil patterns of phases 7 down to 0
    localparam logic [8*CoilW-1:0] HALF_STEP = {4'b1000, 4'b1001, 4'b0001, 4'b0011,
                                                4'b0010, 4'b0110, 4'b0100, 4'b1100};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    t_in_item          in_item = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_item         out_item;
    logic              cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_idx = CFG_SLOWEST;
    logic [DelayW-1:0] cfg_data = '0;

    logic [DelayW-1:0] lim_slowest = SLOWEST_RESET;
    logic [DelayW-1:0] lim_fastest = FASTEST_RESET;
    logic [PhaseW-1:0] motor_phase = '0;
    logic              motor_left = 1'b0;
    logic [DelayW-1:0] motor_delay = DELAY_RESET;
    logic [DelayW-1:0] motor_ticks = '0;

    t_out_item         motor_states_due[$];
    int                fails = 0;
    int                cycles = 0;
    bit                idle_en = 1'b1;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    stepper_half_step_sequencer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    task automatic step_motor_state(input t_in_item it);
        t_out_item res;
        if (it.req_type == REQ_TICK) begin
            if (motor_ticks < DELAY_MAX) begin
                motor_ticks = motor_ticks + 1'b1;
            end
            if (motor_ticks >= motor_delay) begin
                motor_ticks = '0;
                motor_phase = motor_left ? motor_phase - 1'b1 : motor_phase + 1'b1;
            end
        end else begin
            if (it.buttons[BTN_RIGHT]) begin
                motor_left = 1'b0;
            end
            if (it.buttons[BTN_SLOWER] && motor_delay < lim_slowest
                    && motor_delay < DELAY_MAX) begin
                motor_delay = motor_delay + 1'b1;
            end
            if (it.buttons[BTN_LEFT]) begin
                motor_left = 1'b1;
            end
            if (it.buttons[BTN_FASTER] && motor_delay > lim_fastest
                    && motor_delay > DELAY_MIN) begin
                motor_delay = motor_delay - 1'b1;
            end
        end
        res.coil_pattern = HALF_STEP[motor_phase*CoilW +: CoilW];
        res.delay_ms_now = motor_delay;
        res.turning_left = motor_left;
        motor_states_due.push_back(res);
    endtask

    task automatic send_item(input logic kind, input logic [ButtonW-1:0] keys);
        int gap;
        gap = idle_en ? pick_gap() : 0;
        repeat (gap) @(negedge clk) in_valid <= 1'b0;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item.req_type <= kind;
        in_item.buttons <= keys;
        do @(posedge clk); while (in_stall);
        step_motor_state(in_item);
    endtask

    task automatic wait_all_results();
        @(negedge clk) in_valid <= 1'b0;
        while (motor_states_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limits(input logic [DelayW-1:0] slow, input logic [DelayW-1:0] fast);
        wait_all_results();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_SLOWEST;
        cfg_data <= slow;
        @(negedge clk);
        cfg_idx <= CFG_FASTEST;
        cfg_data <= fast;
        @(negedge clk);
        cfg_we <= 1'b0;
        lim_slowest = slow;
        lim_fastest = fast;
    endtask

    task automatic send_random(input t_press_bias bias);
        logic             kind;
        logic [ButtonW-1:0] keys;
        keys = ButtonW'($urandom_range(0, 15));
        case (bias)
            PUSH_SLOWER: begin
                kind = ($urandom_range(0, 9) != 0) ? REQ_BUTTON : REQ_TICK;
                keys[BTN_SLOWER] = 1'b1;
                keys[BTN_FASTER] = ($urandom_range(0, 19) == 0);
            end
            PUSH_FASTER: begin
                kind = ($urandom_range(0, 9) != 0) ? REQ_BUTTON : REQ_TICK;
                keys[BTN_FASTER] = 1'b1;
                keys[BTN_SLOWER] = ($urandom_range(0, 19) == 0);
            end
            default: begin
                kind = ($urandom_range(0, 99) < 60) ? REQ_TICK : REQ_BUTTON;
            end
        endcase
        send_item(kind, keys);
    endtask

    task automatic test_directed_buttons();
        send_item(REQ_TICK, 4'hF);
        send_item(REQ_BUTTON, 4'h0);
        send_item(REQ_BUTTON, 4'h5);
        send_item(REQ_TICK, 4'h0);
        send_item(REQ_BUTTON, 4'h1);
        send_item(REQ_BUTTON, 4'h2);
        send_item(REQ_BUTTON, 4'h8);
        send_item(REQ_BUTTON, 4'hF);
        send_item(REQ_BUTTON, 4'hA);
    endtask

    task automatic test_delay_bounds();
        set_limits(8'd16, 8'd14);
        send_item(REQ_BUTTON, 4'h2);
        send_item(REQ_BUTTON, 4'h2);
        repeat (3) send_item(REQ_BUTTON, 4'h8);
        set_limits(8'd10, 8'd200);
        send_item(REQ_BUTTON, 4'h2);
        send_item(REQ_BUTTON, 4'h8);
        set_limits(8'd0, 8'd255);
        send_item(REQ_BUTTON, 4'hA);
        send_item(REQ_TICK, 4'h5);
    endtask

    task automatic test_random_mix(input logic [DelayW-1:0] slow, input logic [DelayW-1:0] fast,
                                   input int count, input bit with_idle);
        set_limits(slow, fast);
        idle_en = with_idle;
        repeat (count) begin
            send_random(MIX_ALL);
            if ($urandom_range(0, 199) == 0) begin
                wait_all_results();
            end
        end
        idle_en = 1'b1;
    endtask

    task automatic test_delay_sweep();
        set_limits(DELAY_MAX, 8'd0);
        repeat (320) send_random(PUSH_SLOWER);
        repeat (300) send_random(PUSH_FASTER);
    endtask

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (motor_states_due.size() == 0) begin
                $error("result with nothing expected: %p", out_item);
                fails++;
            end else begin
                want = motor_states_due.pop_front();
                if (out_item.coil_pattern !== want.coil_pattern) begin
                    $error("coil_pattern: expected %b, got %b",
                           want.coil_pattern, out_item.coil_pattern);
                    fails++;
                end
                if (out_item.delay_ms_now !== want.delay_ms_now) begin
                    $error("delay_ms_now: expected %0d, got %0d",
                           want.delay_ms_now, out_item.delay_ms_now);
                    fails++;
                end
                if (out_item.turning_left !== want.turning_left) begin
                    $error("turning_left: expected %b, got %b",
                           want.turning_left, out_item.turning_left);
                    fails++;
                end
            end
        end
    end

    initial begin : drive_out_stall
        int n;
        forever begin
            n = pick_gap();
            repeat (n + 1) @(negedge clk) out_stall <= 1'b0;
            n = idle_en ? pick_gap() : 0;
            repeat (n) @(negedge clk) out_stall <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        test_directed_buttons();
        test_delay_bounds();
        test_delay_sweep();
        test_random_mix(SLOWEST_RESET, FASTEST_RESET, 120, 1'b1);
        test_random_mix(8'd4, 8'd1, 180, 1'b1);
        test_random_mix(8'd2, 8'd0, 120, 1'b0);
        test_random_mix(DELAY_MAX, DELAY_MAX, 80, 1'b1);
        test_random_mix(8'd0, 8'd0, 50, 1'b1);
        test_random_mix(DelayW'($urandom_range(0, 255)), DelayW'($urandom_range(0, 255)),
                        60, 1'b1);
        test_random_mix(DelayW'($urandom_range(1, 12)), DelayW'($urandom_range(0, 6)),
                        60, 1'b1);
        wait_all_results();
        repeat (10) @(posedge clk);
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
